@@ hw/rtl/bsfr_pkg.sv @@
`default_nettype none

package bsfr_pkg;

    // Packet store capacity in bytes
    localparam int PACKET_CAPACITY = 64;

    // Fill count must hold the capacity itself
    localparam int CNT_W = $clog2(PACKET_CAPACITY + 1);

    // Field widths fixed by the interface
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 6;
    localparam int MINLEN_W  = 7;
    localparam int CFG_IDX_W = 2;

    // Width used for the too-short length compare
    localparam int LEN_CMP_W = (CNT_W > MINLEN_W) ? CNT_W : MINLEN_W;

    typedef enum logic [1:0] {
        MODE_WAIT    = 2'd0,
        MODE_RECEIVE = 2'd1,
        MODE_ESCAPED = 2'd2
    } rx_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_QUOTE_BYTE = 2'd2,
        CFG_MIN_LENGTH = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

@@ hw/rtl/bsfr_rx_if.sv @@
`default_nettype none

interface bsfr_rx_if;
    logic                         valid;
    logic                         ready;
    logic [bsfr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bsfr_res_if.sv @@
`default_nettype none

interface bsfr_res_if;
    logic                         valid;
    logic                         ready;
    logic [bsfr_pkg::BYTE_W-1:0]  data_byte;
    logic [bsfr_pkg::POS_W-1:0]   position;
    logic                         packet_start;
    logic                         packet_end;
    logic                         too_short;
    logic                         dropped;

    modport source (output valid, output data_byte, output position, output packet_start,
                    output packet_end, output too_short, output dropped, input ready);
    modport sink   (input valid, input data_byte, input position, input packet_start,
                    input packet_end, input too_short, input dropped, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bsfr_cfg_if.sv @@
`default_nettype none

interface bsfr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bsfr_pkg::CFG_IDX_W-1:0]  index;
    logic [bsfr_pkg::BYTE_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/byte_stuffed_frame_receiver_top.sv @@
`default_nettype none

// Byte-stuffed frame receiver.
// rx  : one received serial byte per beat (valid/ready).
// res : one beat per stored packet byte: data_byte, position in the packet,
//       packet_start, packet_end, too_short (on end byte only) and dropped
//       (overflow: byte not stored, receiver falls back to waiting for start).
// cfg : register writes (index 0 start_byte, 1 end_byte, 2 quote_byte,
//       3 min_length), always ready; write only while the block is idle.
// Bytes outside a packet and escaping quote bytes give no result beat.
// Throughput: one byte per cycle while res takes its beats; the input register feeds the frame
// decode, which updates mode and fill count and loads the result register.
// Stall: when res is not taken, the result register holds; rx.ready drops
// as soon as the input register holds a byte that needs the result slot
// (combinational from res.ready); bytes that give no result still drain.
// Reset: registers return to 2/3/16/4, mode to wait-for-start, fill count
// to zero, both pipeline registers empty.
module byte_stuffed_frame_receiver_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    bsfr_cfg_if.sink        cfg,
    bsfr_rx_if.sink         rx,
    bsfr_res_if.source      res
);

    // Configuration registers
    logic [bsfr_pkg::BYTE_W-1:0]   start_byte_reg;
    logic [bsfr_pkg::BYTE_W-1:0]   end_byte_reg;
    logic [bsfr_pkg::BYTE_W-1:0]   quote_byte_reg;
    logic [bsfr_pkg::MINLEN_W-1:0] min_length_reg;

    // Input register
    logic                          s1_valid_reg;
    logic [bsfr_pkg::BYTE_W-1:0]   s1_byte_reg;

    // Frame state
    bsfr_pkg::rx_mode_t            mode_reg, mode_next;
    logic [bsfr_pkg::CNT_W-1:0]    fill_reg, fill_next;

    // Result register
    logic                          res_valid_reg;
    logic [bsfr_pkg::BYTE_W-1:0]   res_byte_reg;
    logic [bsfr_pkg::POS_W-1:0]    res_pos_reg, res_pos_next;
    logic                          res_start_reg, res_end_reg;
    logic                          res_short_reg, res_short_next;
    logic                          res_drop_reg, res_drop_next;

    // Decode
    logic                          store;
    logic                          is_start, is_end;
    logic [bsfr_pkg::CNT_W-1:0]    base;
    logic [bsfr_pkg::CNT_W-1:0]    base_inc;
    logic                          full;
    logic                          s1_advance;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'd2;
            end_byte_reg   <= 8'd3;
            quote_byte_reg <= 8'd16;
            min_length_reg <= 7'd4;
        end
        else if (cfg.valid)
        begin
            case (bsfr_pkg::cfg_index_t'(cfg.index))
                bsfr_pkg::CFG_START_BYTE: start_byte_reg <= cfg.data;
                bsfr_pkg::CFG_END_BYTE:   end_byte_reg   <= cfg.data;
                bsfr_pkg::CFG_QUOTE_BYTE: quote_byte_reg <= cfg.data;
                bsfr_pkg::CFG_MIN_LENGTH: min_length_reg <= cfg.data[bsfr_pkg::MINLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame decode: marker priority start, end, quote
    always_comb
    begin
        mode_next = mode_reg;
        store     = 1'b0;
        is_start  = 1'b0;
        is_end    = 1'b0;
        case (mode_reg)
            bsfr_pkg::MODE_RECEIVE:
            begin
                if (s1_byte_reg == start_byte_reg)
                begin
                    store    = 1'b1;
                    is_start = 1'b1;
                end
                else if (s1_byte_reg == end_byte_reg)
                begin
                    store     = 1'b1;
                    is_end    = 1'b1;
                    mode_next = bsfr_pkg::MODE_WAIT;
                end
                else if (s1_byte_reg == quote_byte_reg)
                begin
                    mode_next = bsfr_pkg::MODE_ESCAPED;
                end
                else
                begin
                    store = 1'b1;
                end
            end
            bsfr_pkg::MODE_ESCAPED:
            begin
                store     = 1'b1;
                mode_next = bsfr_pkg::MODE_RECEIVE;
            end
            default:
            begin
                // wait for start
                if (s1_byte_reg == start_byte_reg)
                begin
                    store     = 1'b1;
                    is_start  = 1'b1;
                    mode_next = bsfr_pkg::MODE_RECEIVE;
                end
                else
                begin
                    mode_next = bsfr_pkg::MODE_WAIT;
                end
            end
        endcase

        // Store path: start byte restarts the count
        base     = is_start ? '0 : fill_reg;
        base_inc = base + bsfr_pkg::CNT_W'(1);
        full     = (base == bsfr_pkg::CNT_W'(bsfr_pkg::PACKET_CAPACITY));
        fill_next = fill_reg;
        res_pos_next   = '0;
        res_short_next = 1'b0;
        res_drop_next  = 1'b0;
        if (store)
        begin
            if (full)
            begin
                // overflow: drop packet, keep count until next start
                res_drop_next = 1'b1;
                mode_next     = bsfr_pkg::MODE_WAIT;
            end
            else
            begin
                fill_next      = base_inc;
                res_pos_next   = bsfr_pkg::POS_W'(base);
                res_short_next = is_end &&
                    (bsfr_pkg::LEN_CMP_W'(base_inc) < bsfr_pkg::LEN_CMP_W'(min_length_reg));
            end
        end
    end

    // Item leaves the input register when its result slot is free or it needs none
    assign s1_advance = s1_valid_reg && (!store || !res_valid_reg || res.ready);
    assign rx.ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bsfr_pkg::MODE_WAIT;
            fill_reg <= '0;
        end
        else if (s1_advance)
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_advance && store)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && store)
        begin
            res_byte_reg  <= s1_byte_reg;
            res_pos_reg   <= res_pos_next;
            res_start_reg <= is_start && !full;
            res_end_reg   <= is_end && !full;
            res_short_reg <= res_short_next;
            res_drop_reg  <= res_drop_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.data_byte    = res_byte_reg;
    assign res.position     = res_pos_reg;
    assign res.packet_start = res_start_reg;
    assign res.packet_end   = res_end_reg;
    assign res.too_short    = res_short_reg;
    assign res.dropped      = res_drop_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bsfr_checker.sv @@
`default_nettype none

module bsfr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [bsfr_pkg::BYTE_W-1:0]   data_byte,
    input wire logic [bsfr_pkg::POS_W-1:0]    position,
    input wire logic                          packet_start,
    input wire logic                          packet_end,
    input wire logic                          too_short,
    input wire logic                          dropped
);

    // Stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(data_byte) && $stable(position)
            && $stable(packet_start) && $stable(packet_end) && $stable(too_short)
            && $stable(dropped))
        else $error("result beat changed while stalled");

    // Dropped beat carries no packet info
    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && dropped |-> position == '0 && !packet_start && !packet_end && !too_short)
        else $error("dropped beat has packet flags set");

    a_short_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && too_short |-> packet_end)
        else $error("too_short without packet_end");

    // Start byte always opens at index zero and never closes
    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && packet_start |-> position == '0 && !packet_end)
        else $error("start byte not at position zero");

endmodule

bind byte_stuffed_frame_receiver_top bsfr_checker u_bsfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .data_byte    (res.data_byte),
    .position     (res.position),
    .packet_start (res.packet_start),
    .packet_end   (res.packet_end),
    .too_short    (res.too_short),
    .dropped      (res.dropped)
);

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfr_pkg::*;

    // Run limits
    localparam int CYCLE_LIMIT   = 200000;
    // Input register plus result register, with a little margin
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_MAX    = 10;

    // One result beat as the block presents it
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              packet_start;
        logic              packet_end;
        logic              too_short;
        logic              dropped;
    } res_beat_t;

    // Tracks the deframer state (mode, fill count, marker registers) and
    // keeps the beats that each accepted byte must produce, oldest first.
    class frame_tracker;
        logic [BYTE_W-1:0]   start_val;
        logic [BYTE_W-1:0]   end_val;
        logic [BYTE_W-1:0]   quote_val;
        logic [MINLEN_W-1:0] min_len;
        rx_mode_t            mode;
        int unsigned         fill;
        res_beat_t           pending_beats[$];
        int unsigned         mismatches;

        function new();
            start_val   = 8'd2;
            end_val     = 8'd3;
            quote_val   = 8'd16;
            min_len     = 7'd4;
            mode        = MODE_WAIT;
            fill        = 0;
            mismatches  = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [BYTE_W-1:0] val);
            case (idx)
                CFG_START_BYTE: start_val = val;
                CFG_END_BYTE:   end_val   = val;
                CFG_QUOTE_BYTE: quote_val = val;
                CFG_MIN_LENGTH: min_len   = val[MINLEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Store one byte into the packet; past capacity the packet is dropped
        function void store_byte(logic [BYTE_W-1:0] b, bit is_start, bit is_end);
            res_beat_t beat;
            if (is_start)
                fill = 0;
            beat = '0;
            beat.data_byte = b;
            if (fill >= PACKET_CAPACITY)
            begin
                beat.dropped = 1'b1;
                mode = MODE_WAIT;
            end
            else
            begin
                beat.position     = POS_W'(fill);
                fill              = fill + 1;
                beat.packet_start = is_start;
                beat.packet_end   = is_end;
                beat.too_short    = is_end && (fill < min_len);
            end
            pending_beats.push_back(beat);
        endfunction

        // Returns 1 when the byte is ignored outright (outside a packet)
        function bit note_rx(logic [BYTE_W-1:0] b);
            bit ignored;
            ignored = 1'b0;
            case (mode)
                MODE_RECEIVE:
                begin
                    // marker priority: start, then end, then quote
                    if (b == start_val)
                        store_byte(b, 1'b1, 1'b0);
                    else if (b == end_val)
                    begin
                        store_byte(b, 1'b0, 1'b1);
                        mode = MODE_WAIT;
                    end
                    else if (b == quote_val)
                        mode = MODE_ESCAPED;
                    else
                        store_byte(b, 1'b0, 1'b0);
                end
                MODE_ESCAPED:
                begin
                    mode = MODE_RECEIVE;
                    store_byte(b, 1'b0, 1'b0);
                end
                default:
                begin
                    if (b == start_val)
                    begin
                        mode = MODE_RECEIVE;
                        store_byte(b, 1'b1, 1'b0);
                    end
                    else
                        ignored = 1'b1;
                end
            endcase
            return ignored;
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t ns: %s", $realtime, msg);
        endfunction

        function void check_beat(res_beat_t got);
            res_beat_t want;
            if (pending_beats.size() == 0)
            begin
                note_error($sformatf("unexpected beat: byte %02h pos %0d s%0b e%0b ts%0b d%0b",
                           got.data_byte, got.position, got.packet_start,
                           got.packet_end, got.too_short, got.dropped));
                return;
            end
            want = pending_beats.pop_front();
            if (got.data_byte !== want.data_byte || got.position !== want.position ||
                got.packet_start !== want.packet_start || got.packet_end !== want.packet_end ||
                got.too_short !== want.too_short || got.dropped !== want.dropped)
                note_error($sformatf({"beat mismatch: exp byte %02h pos %0d s%0b e%0b ts%0b d%0b",
                                      " / got byte %02h pos %0d s%0b e%0b ts%0b d%0b"},
                           want.data_byte, want.position, want.packet_start,
                           want.packet_end, want.too_short, want.dropped,
                           got.data_byte, got.position, got.packet_start,
                           got.packet_end, got.too_short, got.dropped));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bsfr_cfg_if cfg_if ();
    bsfr_rx_if  rx_if ();
    bsfr_res_if res_if ();

    byte_stuffed_frame_receiver_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .rx    (rx_if),
        .res   (res_if)
    );

    frame_tracker tracker = new();

    // Idle odds in percent for each side, changed per phase
    int unsigned rx_idle_pct  = 34;
    int unsigned res_idle_pct = 34;
    // Long result hold-off, handed to the result side as a cycle count
    int unsigned hold_req     = 0;
    // Bytes that were not simply ignored by the block
    int unsigned counted_bytes = 0;
    int unsigned cycle_count   = 0;

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a correct run ends long before this
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off when asked.
    // The hold is counted here, so the sender keeps pushing bytes into the
    // block until its input stalls.
    initial
    begin : res_side
        int unsigned hold_left;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                res_if.ready = 1'b0;
                hold_left--;
            end
            else
                res_if.ready = ($urandom_range(99) >= res_idle_pct);
        end
    end

    // Every accepted result beat goes to the tracker; sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            tracker.check_beat(res_beat_t'{res_if.data_byte, res_if.position,
                                           res_if.packet_start, res_if.packet_end,
                                           res_if.too_short, res_if.dropped});
    end

    // Offer one received byte; entered and left at a falling edge
    task automatic send_rx(input logic [BYTE_W-1:0] b);
        // random idle cycles before the beat, each one with the idle odds
        while ($urandom_range(99) < rx_idle_pct)
            @(negedge clk);
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        if (!tracker.note_rx(b))
            counted_bytes++;
        @(negedge clk);
        rx_if.valid = 1'b0;
    endtask

    // Register write; only called with the block idle
    task automatic write_cfg(input cfg_index_t idx, input logic [BYTE_W-1:0] val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        tracker.write_reg(idx, val);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Wait for every outstanding beat, then let no-result bytes drain
    task automatic wait_drained();
        while (tracker.pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // One framed packet: markers in the body are mostly escaped, sometimes
    // left bare (restart, early close or a quote that escapes the next byte),
    // a few plain bytes get a needless quote, and now and then the end byte is missing.
    task automatic send_packet(input int unsigned body_len);
        logic [BYTE_W-1:0] b;
        send_rx(tracker.start_val);
        for (int unsigned i = 0; i < body_len; i++)
        begin
            b = 8'($urandom_range(255));
            if (b == tracker.start_val || b == tracker.end_val || b == tracker.quote_val)
            begin
                if ($urandom_range(99) < 85)
                    send_rx(tracker.quote_val);
            end
            else if ($urandom_range(99) < 5)
                send_rx(tracker.quote_val);
            send_rx(b);
        end
        if ($urandom_range(99) < 92)
            send_rx(tracker.end_val);
    endtask

    // A settings phase: idle, write all four registers, then traffic.
    // The first packet sits right at the capacity edge so that exact fit
    // or overflow may come up in each phase.
    task automatic run_phase(input logic [BYTE_W-1:0] s_val, input logic [BYTE_W-1:0] e_val,
                             input logic [BYTE_W-1:0] q_val, input int unsigned m_val,
                             input int unsigned budget, input int unsigned idle_pct);
        int unsigned goal;
        int unsigned body_len;
        wait_drained();
        write_cfg(CFG_START_BYTE, s_val);
        write_cfg(CFG_END_BYTE, e_val);
        write_cfg(CFG_QUOTE_BYTE, q_val);
        write_cfg(CFG_MIN_LENGTH, 8'(m_val));
        rx_idle_pct  = idle_pct;
        res_idle_pct = idle_pct;
        goal = counted_bytes + budget;
        send_packet($urandom_range(61, 66));
        while (counted_bytes < goal)
        begin
            if ($urandom_range(99) < 8)
                body_len = $urandom_range(55, 70);
            else
                body_len = $urandom_range(0, 12);
            send_packet(body_len);
            // line noise between packets
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 3)) send_rx(8'($urandom_range(255)));
        end
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] directed [20];

        // Directed bytes under the reset markers (start 02, end 03, quote 10):
        // noise and a quote outside a packet, escaped end/start/quote,
        // the byte extremes, a too-short packet and a restart mid-packet.
        directed = '{
            8'h00, 8'hFF, 8'h10,
            8'h02, 8'hFF, 8'h10, 8'h03, 8'h10, 8'h02, 8'h10, 8'h10, 8'h00, 8'h03,
            8'h02, 8'h03,
            8'h02, 8'h55, 8'h02, 8'hAA, 8'h03
        };

        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_START_BYTE;
        cfg_if.data   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_rx(directed[i]);

        // Long stretch with no idling on either side, HDLC-like markers
        run_phase(8'h7E, 8'h7F, 8'h7D, 0, 150, 0);

        // Result side stalls for a long time while a long packet streams in,
        // so the block backs up and holds its input; then the sender waits
        // for every beat before going on.
        wait_drained();
        rx_idle_pct = 0;
        hold_req    = 150;
        send_packet(40);
        wait_drained();

        // Marker and length extremes
        run_phase(8'h00, 8'hFF, 8'h80, 64, 150, 34);
        run_phase(8'hFF, 8'h00, 8'h01, 1, 150, 34);
        // All markers equal: every marker restarts the packet
        run_phase(8'h55, 8'h55, 8'h55, 63, 110, 34);
        // End and quote equal: end wins
        run_phase(8'hAA, 8'h33, 8'h33, 5, 130, 34);
        // Random settings; markers may collide
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  $urandom_range(64), 170, 34);
        // Back to the reset values
        run_phase(8'd2, 8'd3, 8'd16, 4, 140, 34);

        wait_drained();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
